@@ rtl/core/mcw_pkg.sv @@
// mcw_pkg: shared types, constants and codes of the watchdog supervisor
// used by mcw_seq and by the top level; depends on nothing

package mcw_pkg;

    // bank geometry
    localparam int BANK_SLOTS       = 16;
    localparam int SLOT_W           = 4;
    localparam int DEF_NUM_CHANNELS = 16;

    // health and trigger arithmetic
    localparam logic [6:0]  HEALTH_MAX   = 7'd100;
    localparam logic [6:0]  KICK_GAIN    = 7'd5;
    localparam logic [6:0]  TIMEOUT_LOSS = 7'd20;
    localparam logic [6:0]  CHECK_GAIN   = 7'd1;
    localparam logic [15:0] TRIG_MAX     = 16'hFFFF;

    // escalation thresholds
    localparam logic [7:0]  PRIO_SYSTEM  = 8'd2;
    localparam logic [15:0] TRIG_SYSTEM  = 16'd3;
    localparam logic [7:0]  PRIO_DEGRADE = 8'd3;
    localparam logic [15:0] TRIG_DEGRADE = 16'd5;
    localparam logic [15:0] TRIG_MODULE  = 16'd2;

    typedef enum logic [1:0] {
        MODE_REGISTER   = 2'd0,
        MODE_KICK       = 2'd1,
        MODE_UNREGISTER = 2'd2,
        MODE_CHECK      = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE           = 3'd0,
        ACT_RESTART_TASK   = 3'd1,
        ACT_RESTART_MODULE = 3'd2,
        ACT_SYSTEM_RESTART = 3'd3,
        ACT_DEGRADE        = 3'd4
    } action_t;

    // one request as taken from the input channel
    typedef struct packed {
        mode_t              mode;
        logic [SLOT_W-1:0]  channel;
        logic [31:0]        timeout_req;
        logic [7:0]         priority_req;
        logic [31:0]        now_ms;
    } req_t;

    // one channel entry as held in the bank memory
    typedef struct packed {
        logic [31:0] timeout;
        logic [7:0]  prio;
        logic [31:0] kick_stamp;
        logic [6:0]  health;
        logic [15:0] triggers;
    } entry_t;

    // one result item
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              accepted;
        logic              timed_out;
        action_t           action;
        logic [6:0]        health;
        logic [15:0]       triggers;
        logic              last;
    } result_t;

endpackage

@@ rtl/core/mcw_ram.sv @@
// mcw_ram: generic single-clock ram, one write port, one registered read port
// stands alone, no package needed

module mcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/mcw_seq.sv @@
// mcw_seq: request sequencer, active flags and read-modify-write of channel entries
// depends on mcw_pkg; drives the bank memory instanced at the top level

module mcw_seq
    import mcw_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    output logic              ram_we,
    output logic [SLOT_W-1:0] ram_addr,
    output entry_t            ram_wdata,
    input  entry_t            ram_rdata
);

    localparam int USABLE = (NUM_CHANNELS < BANK_SLOTS) ? NUM_CHANNELS : BANK_SLOTS;
    localparam int CNT_W  = $clog2(USABLE + 1);
    localparam logic [SLOT_W:0]   USABLE_SLOTS = (SLOT_W + 1)'(USABLE);
    localparam logic [SLOT_W-1:0] LAST_IDX     = SLOT_W'(USABLE - 1);
    localparam logic [CNT_W-1:0]  USABLE_CNT   = CNT_W'(USABLE);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_READ   = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    req_t                    req_reg;
    logic [SLOT_W-1:0]       idx_reg, idx_next;
    logic [BANK_SLOTS-1:0]   active_reg, active_next;
    logic [CNT_W-1:0]        total_reg, total_next;

    entry_t      cur;
    logic        live;
    logic        fire;
    logic        reg_ok;
    logic        timed;
    logic        more_above;
    logic [31:0] elapsed;
    logic [15:0] trig_inc;
    logic [7:0]  kick_sum;
    logic [7:0]  gain_sum;
    logic [6:0]  health_kick;
    logic [6:0]  health_gain;
    logic [6:0]  health_loss;

    // escalation ladder on a timed-out channel
    function automatic action_t escalate(input logic [7:0] prio, input logic [15:0] trig);
        action_t act;
        if (prio <= PRIO_SYSTEM && trig >= TRIG_SYSTEM) begin
            act = ACT_SYSTEM_RESTART;
        end else if (prio <= PRIO_DEGRADE && trig >= TRIG_DEGRADE) begin
            act = ACT_DEGRADE;
        end else if (trig >= TRIG_MODULE) begin
            act = ACT_RESTART_MODULE;
        end else begin
            act = ACT_RESTART_TASK;
        end
        return act;
    endfunction

    // entry arithmetic on the word just read
    always_comb begin
        cur         = ram_rdata;
        live        = active_reg[idx_reg];
        elapsed     = req_reg.now_ms - cur.kick_stamp;
        timed       = elapsed > cur.timeout;
        trig_inc    = (cur.triggers == TRIG_MAX) ? cur.triggers : cur.triggers + 16'd1;
        kick_sum    = {1'b0, cur.health} + {1'b0, KICK_GAIN};
        gain_sum    = {1'b0, cur.health} + {1'b0, CHECK_GAIN};
        health_kick = (kick_sum > {1'b0, HEALTH_MAX}) ? HEALTH_MAX : kick_sum[6:0];
        health_gain = (gain_sum > {1'b0, HEALTH_MAX}) ? HEALTH_MAX : gain_sum[6:0];
        health_loss = (cur.health > TIMEOUT_LOSS) ? cur.health - TIMEOUT_LOSS : 7'd0;
        reg_ok      = ({1'b0, req_reg.channel} < USABLE_SLOTS) && !live
                      && (total_reg < USABLE_CNT);
    end

    // any active channel above the current scan index
    always_comb begin
        more_above = 1'b0;
        for (int j = 0; j < BANK_SLOTS; j++) begin
            if (j > int'(idx_reg) && active_reg[j]) begin
                more_above = 1'b1;
            end
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_UPDATE);
    assign fire      = res_valid && res_ready;
    assign ram_addr  = idx_reg;

    // sequencer and per-request update
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        active_next  = active_reg;
        total_next   = total_reg;
        ram_we       = 1'b0;
        ram_wdata    = cur;
        res.slot      = idx_reg;
        res.accepted  = 1'b0;
        res.timed_out = 1'b0;
        res.action    = ACT_NONE;
        res.health    = 7'd0;
        res.triggers  = 16'd0;
        res.last      = 1'b1;

        case (req_reg.mode)
            MODE_REGISTER: begin
                res.accepted = reg_ok;
                if (reg_ok) begin
                    ram_wdata.timeout    = req_reg.timeout_req;
                    ram_wdata.prio       = req_reg.priority_req;
                    ram_wdata.kick_stamp = req_reg.now_ms;
                    ram_wdata.health     = HEALTH_MAX;
                    ram_wdata.triggers   = 16'd0;
                    res.health           = HEALTH_MAX;
                end else if (live) begin
                    res.health   = cur.health;
                    res.triggers = cur.triggers;
                end
            end
            MODE_KICK: begin
                res.accepted = live;
                if (live) begin
                    ram_wdata.kick_stamp = req_reg.now_ms;
                    ram_wdata.health     = health_kick;
                    res.health           = health_kick;
                    res.triggers         = cur.triggers;
                end
            end
            MODE_UNREGISTER: begin
                res.accepted = live;
            end
            MODE_CHECK: begin
                res.accepted = 1'b1;
                res.last     = !more_above;
                if (timed) begin
                    ram_wdata.triggers = trig_inc;
                    ram_wdata.health   = health_loss;
                    res.timed_out      = 1'b1;
                    res.action         = escalate(cur.prio, trig_inc);
                    res.health         = health_loss;
                    res.triggers       = trig_inc;
                end else begin
                    ram_wdata.health = health_gain;
                    res.health       = health_gain;
                    res.triggers     = cur.triggers;
                end
            end
            default: begin
                res.accepted = 1'b0;
            end
        endcase

        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    if (req.mode == MODE_CHECK) begin
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end else begin
                        idx_next   = req.channel;
                        state_next = ST_READ;
                    end
                end
            end
            ST_SCAN: begin
                if (active_reg[idx_reg] && ({1'b0, idx_reg} < USABLE_SLOTS)) begin
                    state_next = ST_READ;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_READ: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (fire) begin
                    case (req_reg.mode)
                        MODE_REGISTER: begin
                            ram_we = reg_ok;
                            if (reg_ok) begin
                                active_next[idx_reg] = 1'b1;
                                total_next           = total_reg + CNT_W'(1);
                            end
                            state_next = ST_IDLE;
                        end
                        MODE_KICK: begin
                            ram_we     = live;
                            state_next = ST_IDLE;
                        end
                        MODE_UNREGISTER: begin
                            if (live) begin
                                active_next[idx_reg] = 1'b0;
                                total_next           = total_reg - CNT_W'(1);
                            end
                            state_next = ST_IDLE;
                        end
                        MODE_CHECK: begin
                            ram_we = 1'b1;
                            if (more_above) begin
                                idx_next   = idx_reg + SLOT_W'(1);
                                state_next = ST_SCAN;
                            end else begin
                                state_next = ST_IDLE;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            active_reg <= '0;
            total_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            active_reg <= active_next;
            total_reg  <= total_next;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (req_valid && req_ready) begin
            req_reg <= req;
        end
    end

    // active count tracks the active flags
    a_total_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg == CNT_W'($countones(active_reg)))
        else $error("active count out of step with active flags");

    // the update state is entered only from the read state, so entry data follows its read
    a_update_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPDATE |->
            ($past(state_reg) == ST_READ || $past(state_reg) == ST_UPDATE))
        else $error("update without a preceding memory read");

    // memory is written only with a result handed on
    a_write_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (res_valid && res_ready))
        else $error("entry written without a result");

    // register, kick and unregister give one final result
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && req_reg.mode != MODE_CHECK) |-> res.last)
        else $error("single request result not marked last");

endmodule

@@ rtl/core/multi_channel_watchdog_supervisor.sv @@
// multi_channel_watchdog_supervisor: top level, bank memory and result register
// depends on mcw_pkg, mcw_ram and mcw_seq
//
// Usage
//   s_* channel takes one request: register, kick, unregister or periodic check of
//   the channel bank, selected by s_mode. m_* channel gives the results: one for a
//   register, kick or unregister, and one per active channel for a check, in
//   ascending channel order, m_last set on the final one (a check of an empty bank
//   gives none).
//   Each channel entry lives in one word of a 16-deep ram with registered read; every
//   touched entry goes through read, update and write back.
//   A register, kick or unregister goes from acceptance through the read and update
//   states and its result is loaded into the output register; the next request is
//   taken back in idle. A check scans the slots in ascending order, passing over
//   inactive ones, and takes each active channel through read and update; the read
//   state covers the ram's registered read in the per-channel read-modify-write.
//   Reset clears the active flags and the active count at once; entry words need no
//   clearing since their contents are used only for active channels.
//   A stalled receiver holds the output register; the sequencer waits with the
//   pending result and no entry is written until it moves on.

module multi_channel_watchdog_supervisor
    import mcw_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [SLOT_W-1:0] s_channel,
    input  logic [31:0]       s_timeout,
    input  logic [7:0]        s_priority_req,
    input  logic [31:0]       s_now_ms,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SLOT_W-1:0] m_slot,
    output logic              m_accepted,
    output logic              m_timed_out,
    output logic [2:0]        m_action,
    output logic [6:0]        m_health,
    output logic [15:0]       m_triggers,
    output logic              m_last
);

    req_t              req;
    result_t           res;
    result_t           out_reg;
    logic              out_valid_reg, out_valid_next;
    logic              res_valid;
    logic              res_ready;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_addr;
    entry_t            ram_wdata;
    entry_t            ram_rdata;

    // request bundle
    assign req.mode         = mode_t'(s_mode);
    assign req.channel      = s_channel;
    assign req.timeout_req  = s_timeout;
    assign req.priority_req = s_priority_req;
    assign req.now_ms       = s_now_ms;

    mcw_seq #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    mcw_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (BANK_SLOTS)
    ) u_bank (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // output register, refilled as it drains
    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    // result ports
    assign m_valid     = out_valid_reg;
    assign m_slot      = out_reg.slot;
    assign m_accepted  = out_reg.accepted;
    assign m_timed_out = out_reg.timed_out;
    assign m_action    = out_reg.action;
    assign m_health    = out_reg.health;
    assign m_triggers  = out_reg.triggers;
    assign m_last      = out_reg.last;

endmodule
